// ----- rtl/stpq_pkg.sv -----
// Shared types, codes and widths of the three-level stable priority queue.
package stpq_pkg;

   localparam int LEVELS          = 3;
   localparam int DEF_QUEUE_DEPTH = 64;
   localparam int DEF_TAG_BITS    = 32;

   localparam int ACTION_W   = 1;
   localparam int SEVERITY_W = 2;
   localparam int TAG_W      = 32;
   localparam int STATUS_W   = 2;

   typedef logic [SEVERITY_W-1:0] level_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD  = 1'b0,
      ACT_CALL = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_CALLED = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_ADDED  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   localparam level_type LVL_WORST = 2'd0;
   localparam level_type LVL_BAD   = 2'd1;
   localparam level_type LVL_FAIR  = 2'd2;

endpackage

// ----- rtl/stpq_req_if.sv -----
// Request channel: add or call beats with valid/ready handshake.
interface stpq_req_if import stpq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [SEVERITY_W-1:0] severity;
   logic [TAG_W-1:0]      patient_tag;

   modport source (output valid, output action, output severity, output patient_tag,
                   input ready);
   modport sink   (input valid, input action, input severity, input patient_tag,
                   output ready);
endinterface

// ----- rtl/stpq_rsp_if.sv -----
// Response channel: one result beat per request beat, valid/ready handshake.
interface stpq_rsp_if import stpq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [TAG_W-1:0]      called_tag;
   logic [SEVERITY_W-1:0] called_severity;

   modport source (output valid, output status, output called_tag, output called_severity,
                   input ready);
   modport sink   (input valid, input status, input called_tag, input called_severity,
                   output ready);
endinterface

// ----- rtl/stable_three_level_priority_queue_core.sv -----
// Top level of the three-level stable priority queue.
//
// Usage:
//   req_ch carries add beats (action add, severity, patient_tag) and call beats
//   (action call). Severity 0 is the worst level; a severity of 3 counts as 2.
//   rsp_ch returns exactly one beat per request, in request order: status
//   called / empty / added / full, plus the tag and level of a called entry
//   (both zero for any other status).
//   An accepted request passes the read stage, registered with the tag RAM
//   read, and then the response register before its response is valid.
//   Throughput: one request per cycle unless rsp_ch.ready stalls, set by the
//   single-port-per-direction tag RAM and the per-level head/count update.
//   Stalls: up to two beats wait inside (read stage and response register);
//   req_ch.ready drops once both are held by a stalled rsp_ch.ready.
//   Reset: all levels empty, heads at zero; the tag RAM is not cleared, since
//   only entries counted as present are ever read. No startup pass.
//   A full level drops the added entry and answers full.
module stable_three_level_priority_queue_core import stpq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int TAG_BITS    = DEF_TAG_BITS
) (
   input  logic        clock,
   input  logic        reset,
   stpq_req_if.sink    req_ch,
   stpq_rsp_if.source  rsp_ch
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = PTR_W + 1;
   localparam int RAM_D  = LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(RAM_D);

   // per-level ring state
   logic [PTR_W-1:0] head_ff  [LEVELS];
   logic [PTR_W-1:0] head_in  [LEVELS];
   logic [CNT_W-1:0] count_ff [LEVELS];
   logic [CNT_W-1:0] count_in [LEVELS];

   // read stage, aligned with RAM read data
   logic       p1_valid_ff, p1_valid_in;
   status_type p1_status_ff, p1_status_in;
   level_type  p1_level_ff, p1_level_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   level_type        rsp_sev_ff, rsp_sev_in;

   logic             accept, p1_move, is_add, is_call;
   level_type        add_level, call_level;
   logic             any_present;
   logic [PTR_W-1:0] wr_pos_lane [LEVELS];
   logic [PTR_W-1:0] wr_pos, rd_pos;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic             ram_wr_en, ram_rd_en, add_full;
   logic [TAG_BITS-1:0] ram_rd_data;
   logic [SUM_W-1:0] sum;

   assign p1_move      = p1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !p1_valid_ff || p1_move;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_add       = (action_type'(req_ch.action) == ACT_ADD);
   assign is_call      = (action_type'(req_ch.action) == ACT_CALL);

   // saturate out-of-range severity to the fair level
   assign add_level = (req_ch.severity > LVL_FAIR) ? LVL_FAIR : level_type'(req_ch.severity);

   // ring tail per level and the first non-empty level
   always_comb begin
      call_level  = LVL_WORST;
      any_present = 1'b0;
      for (int lv = 0; lv < LEVELS; lv++) begin
         sum = SUM_W'(head_ff[lv]) + SUM_W'(count_ff[lv]);
         if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
         end
         wr_pos_lane[lv] = PTR_W'(sum);
      end
      for (int lv = LEVELS - 1; lv >= 0; lv--) begin
         if (count_ff[lv] != '0) begin
            call_level  = level_type'(lv);
            any_present = 1'b1;
         end
      end
   end

   assign wr_pos   = wr_pos_lane[add_level];
   assign rd_pos   = head_ff[call_level];
   assign add_full = (count_ff[add_level] == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      case (add_level)
         LVL_WORST: wr_addr = ADDR_W'(wr_pos);
         LVL_BAD:   wr_addr = ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_pos);
         default:   wr_addr = ADDR_W'(2 * QUEUE_DEPTH) + ADDR_W'(wr_pos);
      endcase
      case (call_level)
         LVL_WORST: rd_addr = ADDR_W'(rd_pos);
         LVL_BAD:   rd_addr = ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rd_pos);
         default:   rd_addr = ADDR_W'(2 * QUEUE_DEPTH) + ADDR_W'(rd_pos);
      endcase
   end

   assign ram_wr_en = accept && is_add && !add_full;
   assign ram_rd_en = accept && is_call && any_present;

   // head/count update: at most one level changes per beat
   always_comb begin
      for (int lv = 0; lv < LEVELS; lv++) begin
         head_in[lv]  = head_ff[lv];
         count_in[lv] = count_ff[lv];
         if (ram_wr_en && add_level == level_type'(lv)) begin
            count_in[lv] = count_ff[lv] + CNT_W'(1);
         end
         if (ram_rd_en && call_level == level_type'(lv)) begin
            count_in[lv] = count_ff[lv] - CNT_W'(1);
            if (head_ff[lv] == PTR_W'(QUEUE_DEPTH - 1)) begin
               head_in[lv] = '0;
            end else begin
               head_in[lv] = head_ff[lv] + PTR_W'(1);
            end
         end
      end
   end

   always_comb begin
      p1_valid_in  = p1_valid_ff;
      p1_status_in = p1_status_ff;
      p1_level_in  = p1_level_ff;
      if (p1_move) begin
         p1_valid_in = 1'b0;
      end
      if (accept) begin
         p1_valid_in = 1'b1;
         p1_level_in = call_level;
         if (is_add) begin
            p1_status_in = add_full ? ST_FULL : ST_ADDED;
         end else begin
            p1_status_in = any_present ? ST_CALLED : ST_EMPTY;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_sev_in    = rsp_sev_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (p1_move) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = p1_status_ff;
         if (p1_status_ff == ST_CALLED) begin
            rsp_tag_in = TAG_W'(ram_rd_data);
            rsp_sev_in = p1_level_ff;
         end else begin
            rsp_tag_in = '0;
            rsp_sev_in = LVL_WORST;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int lv = 0; lv < LEVELS; lv++) begin
            head_ff[lv]  <= '0;
            count_ff[lv] <= '0;
         end
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int lv = 0; lv < LEVELS; lv++) begin
            head_ff[lv]  <= head_in[lv];
            count_ff[lv] <= count_in[lv];
         end
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_status_ff  <= p1_status_in;
      p1_level_ff   <= p1_level_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_sev_ff    <= rsp_sev_in;
   end

   stpq_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (RAM_D)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr),
      .wr_data (TAG_BITS'(req_ch.patient_tag)),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.called_tag      = rsp_tag_ff;
   assign rsp_ch.called_severity = rsp_sev_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= CNT_W'(QUEUE_DEPTH) && count_ff[1] <= CNT_W'(QUEUE_DEPTH)
      && count_ff[2] <= CNT_W'(QUEUE_DEPTH))
      else $error("level count exceeds ring depth");

   a_empty_call_keeps_state: assert property (@(posedge clock) disable iff (reset)
      accept && is_call && !any_present |=>
      count_ff[0] == '0 && count_ff[1] == '0 && count_ff[2] == '0)
      else $error("call on empty queue changed level counts");

   a_full_add_drops: assert property (@(posedge clock) disable iff (reset)
      accept && is_add && add_full |=> p1_status_ff == ST_FULL
      && count_ff[0] == $past(count_ff[0]) && count_ff[1] == $past(count_ff[1])
      && count_ff[2] == $past(count_ff[2]))
      else $error("add to full level was not dropped");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_CALLED |->
      rsp_tag_ff == '0 && rsp_sev_ff == LVL_WORST)
      else $error("non-call response carries tag or level");
`endif

endmodule

// ----- rtl/stpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module stpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/stable_three_level_priority_queue_core_test.sv -----
// Self-checking testbench for the three-level stable priority queue core.
`timescale 1ns / 100ps

module stable_three_level_priority_queue_core_test;
   import stpq_pkg::*;

   localparam int CLK_PERIOD_NS   = 8;
   localparam int RESET_CYCLES    = 8;
   localparam int QUEUE_DEPTH     = DEF_QUEUE_DEPTH;
   localparam int TAG_BITS        = DEF_TAG_BITS;
   localparam int RANDOM_ITEMS    = 1500;
   localparam int HOLD_START      = 500;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int SETTLE_CYCLES   = 10;
   localparam int WATCHDOG_CYCLES = 400000;

   localparam logic [TAG_W-1:0] STORED_TAG_MASK = {TAG_W{1'b1}} >> (TAG_W - TAG_BITS);
   localparam level_type        SEV_SATURATE    = 2'd3;

   localparam int SINK_STEADY = 0;
   localparam int SINK_LIGHT  = 1;
   localparam int SINK_HEAVY  = 2;

   typedef enum int {MIX_FILL, MIX_MIXED, MIX_DRAIN} mix_kind_type;

   typedef struct packed {
      status_type       status;
      logic [TAG_W-1:0] called_tag;
      level_type        called_severity;
   } triage_result_type;

   typedef struct packed {
      action_type        act;
      level_type         sev;
      logic [TAG_W-1:0]  tag;
      bit                has_answer;
      triage_result_type answer;
   } triage_row_type;

   localparam triage_result_type NO_ANSWER = '{ST_CALLED, '0, LVL_WORST};

   localparam triage_row_type GUIDED_ROWS [20] = '{
      '{ACT_CALL, LVL_WORST,    32'h0000_0000, 1'b1, '{ST_EMPTY,  32'h0000_0000, LVL_WORST}},
      '{ACT_ADD,  LVL_WORST,    32'hFFFF_FFFF, 1'b1, '{ST_ADDED,  32'h0000_0000, LVL_WORST}},
      '{ACT_ADD,  LVL_BAD,      32'h0000_0000, 1'b1, '{ST_ADDED,  32'h0000_0000, LVL_WORST}},
      '{ACT_ADD,  LVL_FAIR,     32'h1234_5678, 1'b1, '{ST_ADDED,  32'h0000_0000, LVL_WORST}},
      '{ACT_ADD,  SEV_SATURATE, 32'hA5A5_A5A5, 1'b1, '{ST_ADDED,  32'h0000_0000, LVL_WORST}},
      '{ACT_ADD,  LVL_BAD,      32'h5A5A_5A5A, 1'b1, '{ST_ADDED,  32'h0000_0000, LVL_WORST}},
      '{ACT_CALL, LVL_FAIR,     32'hDEAD_BEEF, 1'b1, '{ST_CALLED, 32'hFFFF_FFFF, LVL_WORST}},
      '{ACT_CALL, LVL_WORST,    32'h0000_0000, 1'b1, '{ST_CALLED, 32'h0000_0000, LVL_BAD}},
      '{ACT_CALL, LVL_WORST,    32'h0000_0000, 1'b1, '{ST_CALLED, 32'h5A5A_5A5A, LVL_BAD}},
      '{ACT_CALL, LVL_WORST,    32'h0000_0000, 1'b1, '{ST_CALLED, 32'h1234_5678, LVL_FAIR}},
      '{ACT_CALL, LVL_WORST,    32'h0000_0000, 1'b1, '{ST_CALLED, 32'hA5A5_A5A5, LVL_FAIR}},
      '{ACT_CALL, SEV_SATURATE, 32'hFFFF_FFFF, 1'b1, '{ST_EMPTY,  32'h0000_0000, LVL_WORST}},
      '{ACT_ADD,  LVL_FAIR,     32'h0000_0001, 1'b0, NO_ANSWER},
      '{ACT_ADD,  LVL_WORST,    32'h8000_0000, 1'b0, NO_ANSWER},
      '{ACT_CALL, LVL_BAD,      32'h0F0F_0F0F, 1'b0, NO_ANSWER},
      '{ACT_ADD,  LVL_BAD,      32'h7FFF_FFFF, 1'b0, NO_ANSWER},
      '{ACT_ADD,  SEV_SATURATE, 32'h0000_FFFF, 1'b0, NO_ANSWER},
      '{ACT_CALL, LVL_WORST,    32'h0000_0000, 1'b0, NO_ANSWER},
      '{ACT_CALL, LVL_WORST,    32'h0000_0000, 1'b0, NO_ANSWER},
      '{ACT_CALL, LVL_WORST,    32'h0000_0000, 1'b0, NO_ANSWER}
   };

   logic clock = 1'b0;
   logic reset;

   stpq_req_if req_ch ();
   stpq_rsp_if rsp_ch ();

   stable_three_level_priority_queue_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(CLK_PERIOD_NS / 2.0) clock = ~clock;

   // Predicted waiting room: one ring of tags per severity level.
   logic [TAG_W-1:0] ward_tags  [LEVELS][QUEUE_DEPTH];
   int               ward_head  [LEVELS];
   int               ward_count [LEVELS];

   triage_result_type awaited_responses [$];
   int                error_count = 0;
   int                burst_left  = 0;

   function automatic triage_result_type triage_outcome(action_type act, level_type sev,
                                                        logic [TAG_W-1:0] tag);
      triage_result_type res;
      int                lv;
      int                slot;
      res = '{ST_EMPTY, '0, LVL_WORST};
      if (act == ACT_ADD) begin
         lv = (sev > LVL_FAIR) ? int'(LVL_FAIR) : int'(sev);
         if (ward_count[lv] >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            slot = (ward_head[lv] + ward_count[lv]) % QUEUE_DEPTH;
            ward_tags[lv][slot] = tag & STORED_TAG_MASK;
            ward_count[lv]++;
            res.status = ST_ADDED;
         end
      end else begin
         for (lv = 0; lv < LEVELS; lv++) begin
            if (ward_count[lv] != 0) begin
               res = '{ST_CALLED, ward_tags[lv][ward_head[lv]], level_type'(lv)};
               ward_head[lv] = (ward_head[lv] + 1) % QUEUE_DEPTH;
               ward_count[lv]--;
               break;
            end
         end
      end
      return res;
   endfunction

   // Offer one request beat, record its outcome once accepted, then maybe idle.
   task automatic offer_beat(action_type act, level_type sev, logic [TAG_W-1:0] tag,
                             bit has_answer, triage_result_type answer);
      triage_result_type predicted;
      int                gap;
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.severity    <= sev;
      req_ch.patient_tag <= tag;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predicted = triage_outcome(act, sev, tag);
      awaited_responses.push_back(has_answer ? answer : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      mix_kind_type mix;
      int           seg_left;
      int           fav;
      int           add_pct;
      int           random_sent;
      int           drain_wait;
      action_type   act;
      level_type    sev;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_ADD;
      req_ch.severity    = LVL_WORST;
      req_ch.patient_tag = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (GUIDED_ROWS[i])
         offer_beat(GUIDED_ROWS[i].act, GUIDED_ROWS[i].sev, GUIDED_ROWS[i].tag,
                    GUIDED_ROWS[i].has_answer, GUIDED_ROWS[i].answer);

      // Segments bias toward one level so rings fill to full and drain to empty.
      seg_left    = 0;
      random_sent = 0;
      mix         = MIX_FILL;
      fav         = 0;
      add_pct     = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (seg_left == 0) begin
            mix = (random_sent == 0) ? MIX_FILL : mix_kind_type'($urandom_range(0, 2));
            seg_left = (mix == MIX_FILL) ? $urandom_range(100, 180) : $urandom_range(40, 160);
            fav = $urandom_range(0, 3);
            case (mix)
               MIX_FILL:  add_pct = 95;
               MIX_MIXED: add_pct = 50;
               default:   add_pct = 8;
            endcase
         end
         act = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_CALL;
         sev = ($urandom_range(0, 9) < 8) ? level_type'(fav) : level_type'($urandom_range(0, 3));
         offer_beat(act, sev, $urandom(), 1'b0, NO_ANSWER);
         seg_left--;
         random_sent++;
      end
      req_ch.valid <= 1'b0;

      drain_wait = 0;
      while (awaited_responses.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_responses.size() != 0) begin
         $error("%0d expected response beats never arrived", awaited_responses.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Response sink: random stall pattern plus one long hold-off to back up the core.
   initial begin
      int sink_cycle;
      int run_left;
      int mode;
      rsp_ch.ready = 1'b0;
      sink_cycle   = 0;
      run_left     = 0;
      mode         = SINK_STEADY;
      forever begin
         @(posedge clock);
         sink_cycle++;
         if (run_left == 0) begin
            mode     = $urandom_range(SINK_STEADY, SINK_HEAVY);
            run_left = $urandom_range(10, 120);
         end
         run_left--;
         if (sink_cycle >= HOLD_START && sink_cycle < HOLD_START + HOLD_CYCLES) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               SINK_STEADY: rsp_ch.ready <= 1'b1;
               SINK_LIGHT:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default:     rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      triage_result_type want;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (awaited_responses.size() == 0) begin
            $error("response beat with nothing expected: status %0d tag %h",
                   rsp_ch.status, rsp_ch.called_tag);
            error_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.called_tag !== want.called_tag) begin
               $error("called_tag: expected %h, actual %h", want.called_tag,
                      rsp_ch.called_tag);
               error_count++;
            end
            if (rsp_ch.called_severity !== want.called_severity) begin
               $error("called_severity: expected %0d, actual %0d", want.called_severity,
                      rsp_ch.called_severity);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(WATCHDOG_CYCLES * CLK_PERIOD_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule
